>>> hdl/lssf_pkg.sv
// ----------------------------------------------------------------------------
// lssf_pkg
// Shared types and constants for the least-squares slope fit block.
// ----------------------------------------------------------------------------
`default_nettype none
package lssf_pkg;

    localparam int WIDE_BITS  = 96;
    localparam int QUOT_BITS  = 34;
    localparam int SLOPE_SCALE = 2000;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [1:0] STATUS_SAT      = 2'd3;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MUL,
        ST_FORM,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accum;
        logic clear;
        logic mul_start;
        logic form;
        logic div_start;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

>>> hdl/lssf_datapath.sv
// ----------------------------------------------------------------------------
// lssf_datapath
// Running sums, product steps and a restoring divider for the slope fit.
// ----------------------------------------------------------------------------
`default_nettype none
module lssf_datapath #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire lssf_pkg::cmd_t cmd,
    output lssf_pkg::stat_t     stat,
    input  wire [15:0]          sample_x,
    input  wire [15:0]          sample_y,
    output logic [31:0]         slope_scaled,
    output logic [1:0]          status,
    output logic [12:0]         sample_total
);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int SQW = 2 * SAMPLE_BITS + CW;
    localparam int WB  = lssf_pkg::WIDE_BITS;
    localparam int QB  = lssf_pkg::QUOT_BITS;
    localparam int DIVC = 2 * WB;
    localparam int HL  = (SQW + 1) / 2;
    localparam int PW  = SW + HL + 2;

    logic [CW-1:0]          count_reg;
    logic                   ovf_reg;
    logic signed [SW-1:0]   sx_reg, sy_reg;
    logic signed [SQW-1:0]  sxx_reg, sxy_reg;

    logic signed [SAMPLE_BITS-1:0] x_s, y_s;
    assign x_s = sample_x[SAMPLE_BITS-1:0];
    assign y_s = sample_y[SAMPLE_BITS-1:0];

    logic signed [2*SAMPLE_BITS-1:0] xx_reg, xy_reg;
    logic                            pend_reg;
    logic                            full;
    assign full = (count_reg == CW'(MAX_SAMPLES));

    always_ff @(posedge aclk) begin
        xx_reg <= x_s * x_s;
        xy_reg <= x_s * y_s;
        if (!aresetn || cmd.clear) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            sxy_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            pend_reg <= cmd.accum && !full;
            if (pend_reg) begin
                sxx_reg <= sxx_reg + SQW'(xx_reg);
                sxy_reg <= sxy_reg + SQW'(xy_reg);
            end
            if (cmd.accum) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                    sx_reg    <= sx_reg + SW'(x_s);
                    sy_reg    <= sy_reg + SW'(y_s);
                end
            end
        end
    end

    // four products, each from two signed partial products, one per cycle
    logic [2:0]             mstep_reg;
    logic                   mbusy_reg;
    logic signed [WB-1:0]   p_reg [4];
    logic signed [SW:0]     ma;
    logic signed [SQW:0]    mb;
    logic signed [HL:0]     mh;
    logic signed [WB-1:0]   num_reg, den_reg;

    always_comb begin
        unique case (mstep_reg[2:1])
            2'd0: begin
                ma = (SW+1)'($signed({1'b0, count_reg}));
                mb = (SQW+1)'(sxy_reg);
            end
            2'd1: begin
                ma = (SW+1)'(sx_reg);
                mb = (SQW+1)'(sy_reg);
            end
            2'd2: begin
                ma = (SW+1)'($signed({1'b0, count_reg}));
                mb = (SQW+1)'(sxx_reg);
            end
            default: begin
                ma = (SW+1)'(sx_reg);
                mb = (SQW+1)'(sx_reg);
            end
        endcase
        if (mstep_reg[0]) mh = (HL+1)'($signed(mb[SQW:HL]));
        else              mh = $signed({1'b0, mb[HL-1:0]});
    end

    logic signed [PW-1:0] pp;
    assign pp = ma * mh;

    // restoring divider
    logic [WB+11:0]  dividend_reg;
    logic [WB+12:0]  rem_reg;
    logic [QB-1:0]   q_reg;
    logic            big_reg;
    logic [7:0]      dcnt_reg;
    logic            neg_reg;
    logic            zden_reg;
    logic [WB+12:0]  rem_sh, rem_sub;
    logic [WB-1:0]   num_mag;

    assign num_mag = num_reg[WB-1] ? WB'(-num_reg) : WB'(num_reg);
    assign rem_sh  = {rem_reg[WB+11:0], dividend_reg[WB+11]};
    assign rem_sub = rem_sh - (WB+13)'(den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            mstep_reg <= '0;
        end else if (cmd.mul_start) begin
            mbusy_reg <= 1'b1;
            mstep_reg <= '0;
        end else if (mbusy_reg) begin
            if (mstep_reg[0]) begin
                p_reg[mstep_reg[2:1]] <= p_reg[mstep_reg[2:1]] + (WB'(pp) <<< HL);
            end else begin
                p_reg[mstep_reg[2:1]] <= WB'(pp);
            end
            mstep_reg <= mstep_reg + 1'b1;
            if (mstep_reg == 3'd7) mbusy_reg <= 1'b0;
        end
        if (cmd.form) begin
            num_reg <= p_reg[0] - p_reg[1];
            den_reg <= p_reg[2] - p_reg[3];
        end
        if (cmd.div_start) begin
            neg_reg      <= num_reg[WB-1];
            zden_reg     <= (den_reg == '0) || den_reg[WB-1];
            dividend_reg <= (WB+12)'(num_mag) * (WB+12)'(lssf_pkg::SLOPE_SCALE);
            rem_reg      <= '0;
            q_reg        <= '0;
            big_reg      <= 1'b0;
            dcnt_reg     <= 8'(WB + 12);
        end else if (cmd.div_step && dcnt_reg != 0) begin
            dividend_reg <= {dividend_reg[WB+10:0], 1'b0};
            dcnt_reg     <= dcnt_reg - 1'b1;
            if (!rem_sub[WB+12]) rem_reg <= rem_sub;
            else                 rem_reg <= rem_sh;
            if (!big_reg) begin
                q_reg <= {q_reg[QB-2:0], !rem_sub[WB+12]};
                if (q_reg[QB-2]) big_reg <= 1'b1;
            end
        end
    end

    assign stat.mul_done = mbusy_reg && (mstep_reg == 3'd7);
    assign stat.div_done = (dcnt_reg == 0);

    logic [QB-1:0] qv;
    assign qv = q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            sample_total <= 13'(count_reg);
            if (ovf_reg) begin
                status <= lssf_pkg::STATUS_OVERFLOW;
                slope_scaled <= '0;
            end else if (zden_reg) begin
                status <= lssf_pkg::STATUS_ZERO_DEN;
                slope_scaled <= '0;
            end else if (!neg_reg) begin
                if (big_reg || qv > QB'(32'h7FFF_FFFF)) begin
                    status <= lssf_pkg::STATUS_SAT;
                    slope_scaled <= 32'h7FFF_FFFF;
                end else begin
                    status <= lssf_pkg::STATUS_OK;
                    slope_scaled <= qv[31:0];
                end
            end else begin
                if (big_reg || qv > QB'(32'h8000_0000)) begin
                    status <= lssf_pkg::STATUS_SAT;
                    slope_scaled <= 32'h8000_0000;
                end else begin
                    status <= lssf_pkg::STATUS_OK;
                    slope_scaled <= 32'(-qv[31:0]);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/lssf_ctrl.sv
// ----------------------------------------------------------------------------
// lssf_ctrl
// Sequencer for accumulation, final products, division and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module lssf_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire                 s_tlast,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output lssf_pkg::cmd_t      cmd,
    input  wire lssf_pkg::stat_t stat
);
    lssf_pkg::state_t state_reg, state_next;
    logic             valid_reg, valid_next;
    logic             wait_reg, wait_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lssf_pkg::ST_ACCUM;
            valid_reg <= 1'b0;
            wait_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            wait_reg  <= wait_next;
        end
    end

    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        wait_next  = 1'b0;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            lssf_pkg::ST_ACCUM: begin
                s_tready  = 1'b1;
                cmd.accum = s_tvalid;
                if (s_tvalid && s_tlast) state_next = lssf_pkg::ST_MUL;
            end
            lssf_pkg::ST_MUL: begin
                // wait for the last square and product to land in the sums
                if (!wait_reg) begin
                    wait_next = 1'b1;
                end else begin
                    cmd.mul_start = 1'b1;
                    state_next = lssf_pkg::ST_FORM;
                end
            end
            lssf_pkg::ST_FORM: begin
                if (stat.mul_done) begin
                    wait_next = 1'b1;
                end
                if (wait_reg) begin
                    cmd.form = 1'b1;
                    state_next = lssf_pkg::ST_DIV;
                end
            end
            lssf_pkg::ST_DIV: begin
                if (!wait_reg) begin
                    cmd.div_start = 1'b1;
                    wait_next = 1'b1;
                end else begin
                    cmd.div_step = 1'b1;
                    wait_next = 1'b1;
                    if (stat.div_done) begin
                        wait_next = 1'b0;
                        state_next = lssf_pkg::ST_OUT;
                    end
                end
            end
            default: begin
                if (!valid_reg) begin
                    cmd.finish = 1'b1;
                    cmd.clear  = 1'b1;
                    valid_next = 1'b1;
                    state_next = lssf_pkg::ST_ACCUM;
                end
            end
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/least_squares_slope_fit.sv
// ----------------------------------------------------------------------------
// least_squares_slope_fit
// Least-squares slope of a run of (x, y) pairs, scaled by 2000 and saturated.
// ----------------------------------------------------------------------------
// input: non-last pairs are accepted back to back
// last pair: the result is set by eight serial partial products and a one-bit-per-cycle
//   restoring divide over 108 dividend bits; the input is held off until the result
//   is valid, longer if the last result still waits
// reset: aresetn low clears the sums, the count and the output valid
`default_nettype none
module least_squares_slope_fit #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [31:0]  s_tdata,   // sample_x, sample_y
    input  wire         s_tlast,   // is_last
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // slope_scaled, status, sample_total, zero fill
);
    lssf_pkg::cmd_t  cmd;
    lssf_pkg::stat_t stat;
    logic [31:0] slope;
    logic [1:0]  st;
    logic [12:0] tot;

    lssf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .stat(stat)
    );

    lssf_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .sample_x(s_tdata[15:0]), .sample_y(s_tdata[31:16]),
        .slope_scaled(slope), .status(st), .sample_total(tot)
    );

    assign m_tdata = {1'b0, tot, st, slope};
endmodule
`default_nettype wire
